/* hw/rtl/tbc_pkg.sv */
// Shared types, widths and saturation helpers for the barycentric weight unit.
// No dependencies; every other file takes its names from here.
`default_nettype none
package tbc_pkg;

    localparam int COORD_FRAC_BITS  = 12;
    localparam int WEIGHT_FRAC_BITS = 16;

    localparam int IN_W   = 24;
    localparam int OUT_W  = 25;
    localparam int DIFF_W = IN_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int EDGE_W = PROD_W + 1;

    // Unsigned divider: magnitudes of edge sums fit EDGE_W-1 bits.
    localparam int DIV_DW    = EDGE_W - 1;
    localparam int DIV_NW    = DIV_DW + WEIGHT_FRAC_BITS;
    localparam int DIV_QBITS = OUT_W + 1;
    localparam int DIV_LAT   = DIV_QBITS + 1;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic signed [OUT_W-1:0] W_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] W_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [OUT_W+1:0] W_ONE = (OUT_W+2)'(1) << WEIGHT_FRAC_BITS;

    typedef struct packed {
        logic signed [IN_W-1:0] ax;
        logic signed [IN_W-1:0] ay;
        logic signed [IN_W-1:0] aw;
        logic signed [IN_W-1:0] bx;
        logic signed [IN_W-1:0] by;
        logic signed [IN_W-1:0] bw;
        logic signed [IN_W-1:0] cx;
        logic signed [IN_W-1:0] cy;
        logic signed [IN_W-1:0] cw;
        logic signed [IN_W-1:0] px;
        logic signed [IN_W-1:0] py;
    } tbc_item_t;

    typedef struct packed {
        tbc_item_t item;
        logic      zero_w;
    } tbc_word_t;

    function automatic logic [IN_W-1:0] sat_coord(input logic [DIV_QBITS-1:0] q,
                                                  input logic ovf, input logic neg);
        logic [DIV_QBITS-1:0] lim;
        logic [DIV_QBITS-1:0] q_neg;
        logic [IN_W-1:0]      res;
        lim   = DIV_QBITS'(1) << (IN_W - 1);
        q_neg = DIV_QBITS'(0) - q;
        if (neg) begin
            if (ovf || q > lim) res = lim[IN_W-1:0];
            else res = q_neg[IN_W-1:0];
        end else begin
            if (ovf || q >= lim) res = {1'b0, {(IN_W-1){1'b1}}};
            else res = q[IN_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [OUT_W-1:0] sat_weight(input logic [DIV_QBITS-1:0] q,
                                                    input logic ovf, input logic neg);
        logic [DIV_QBITS-1:0] lim;
        logic [DIV_QBITS-1:0] q_neg;
        logic [OUT_W-1:0]     res;
        lim   = DIV_QBITS'(1) << (OUT_W - 1);
        q_neg = DIV_QBITS'(0) - q;
        if (neg) begin
            if (ovf || q > lim) res = lim[OUT_W-1:0];
            else res = q_neg[OUT_W-1:0];
        end else begin
            if (ovf || q >= lim) res = {1'b0, {(OUT_W-1){1'b1}}};
            else res = q[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/tbc_front.sv */
// Front end: registers the incoming word and flags a zero w on any vertex.
// Depends on tbc_pkg.
`default_nettype none
module tbc_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_a_x,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_a_y,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_a_w,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_b_x,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_b_y,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_b_w,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_c_x,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_c_y,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_c_w,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_point_x,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_point_y,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output tbc_pkg::tbc_word_t                   out_word
);

    logic               valid_reg;
    tbc_pkg::tbc_word_t word_reg;
    tbc_pkg::tbc_word_t word_next;

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb begin
        word_next.item.ax = s_vertex_a_x;
        word_next.item.ay = s_vertex_a_y;
        word_next.item.aw = s_vertex_a_w;
        word_next.item.bx = s_vertex_b_x;
        word_next.item.by = s_vertex_b_y;
        word_next.item.bw = s_vertex_b_w;
        word_next.item.cx = s_vertex_c_x;
        word_next.item.cy = s_vertex_c_y;
        word_next.item.cw = s_vertex_c_w;
        word_next.item.px = s_point_x;
        word_next.item.py = s_point_y;
        word_next.zero_w  = (s_vertex_a_w == '0) || (s_vertex_b_w == '0) ||
                            (s_vertex_c_w == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= word_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/tbc_queue.sv */
// Short flop queue between front and back end.
// Depends on tbc_pkg.
`default_nettype none
module tbc_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tbc_pkg::tbc_word_t  in_word,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output tbc_pkg::tbc_word_t       out_word
);

    tbc_pkg::tbc_word_t              mem_reg [tbc_pkg::QUEUE_DEPTH];
    logic [tbc_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [tbc_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [tbc_pkg::QUEUE_AW:0]      count_reg;
    logic [tbc_pkg::QUEUE_AW:0]      count_next;
    logic                            push;
    logic                            pop;

    assign in_ready  = (count_reg != (tbc_pkg::QUEUE_AW+1)'(tbc_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_word  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/tbc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on tbc_pkg.
`default_nettype none
module tbc_div (
    input  wire logic                             aclk,
    input  wire logic                             en,
    input  wire logic [tbc_pkg::DIV_NW-1:0]       n_in,
    input  wire logic [tbc_pkg::DIV_DW-1:0]       d_in,
    output logic [tbc_pkg::DIV_QBITS-1:0]         q_out,
    output logic                                  ovf_out
);

    logic [tbc_pkg::DIV_DW-1:0]    r_reg   [tbc_pkg::DIV_QBITS];
    logic [tbc_pkg::DIV_DW-1:0]    d_reg   [tbc_pkg::DIV_QBITS];
    logic [tbc_pkg::DIV_QBITS-1:0] nlo_reg [tbc_pkg::DIV_QBITS];
    logic [tbc_pkg::DIV_QBITS-1:0] q_reg   [tbc_pkg::DIV_QBITS+1];
    logic                          ovf_reg [tbc_pkg::DIV_QBITS+1];
    logic                          ovf_next;

    assign ovf_next = ((tbc_pkg::DIV_DW + tbc_pkg::DIV_QBITS)'(n_in) >=
                       {d_in, {tbc_pkg::DIV_QBITS{1'b0}}});

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= tbc_pkg::DIV_DW'(n_in >> tbc_pkg::DIV_QBITS);
            d_reg[0]   <= d_in;
            nlo_reg[0] <= n_in[tbc_pkg::DIV_QBITS-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar i = 1; i <= tbc_pkg::DIV_QBITS; i++) begin : g_stage
        logic [tbc_pkg::DIV_DW:0] trial;
        logic [tbc_pkg::DIV_DW:0] diff;
        logic                     ge;

        assign trial = {r_reg[i-1], nlo_reg[i-1][tbc_pkg::DIV_QBITS-1]};
        assign diff  = trial - {1'b0, d_reg[i-1]};
        assign ge    = !diff[tbc_pkg::DIV_DW];

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[i]   <= {q_reg[i-1][tbc_pkg::DIV_QBITS-2:0], ge};
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end

        if (i < tbc_pkg::DIV_QBITS) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[i]   <= ge ? diff[tbc_pkg::DIV_DW-1:0]
                                     : trial[tbc_pkg::DIV_DW-1:0];
                    d_reg[i]   <= d_reg[i-1];
                    nlo_reg[i] <= nlo_reg[i-1] << 1;
                end
            end
        end
    end

    assign q_out   = q_reg[tbc_pkg::DIV_QBITS];
    assign ovf_out = ovf_reg[tbc_pkg::DIV_QBITS];

endmodule
`default_nettype wire

/* hw/rtl/tbc_back.sv */
// Back end: perspective divide, edge functions, weight divide and output register.
// Depends on tbc_pkg and tbc_div.
`default_nettype none
module tbc_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire tbc_pkg::tbc_word_t                 in_word,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [tbc_pkg::OUT_W-1:0]        m_weight_alpha,
    output logic signed [tbc_pkg::OUT_W-1:0]        m_weight_beta,
    output logic signed [tbc_pkg::OUT_W-1:0]        m_weight_gamma,
    output logic                                    m_degenerate
);

    typedef struct packed {
        logic signed [tbc_pkg::IN_W-1:0] px;
        logic signed [tbc_pkg::IN_W-1:0] py;
        logic                            zero_w;
        logic [5:0]                      neg;
    } side1_t;

    typedef struct packed {
        logic degen;
        logic neg_a;
        logic neg_b;
    } side2_t;

    logic adv;
    logic m_valid_reg;

    assign adv      = !m_valid_reg || m_ready;
    assign in_ready = adv;
    assign m_valid  = m_valid_reg;

    // perspective divide
    logic signed [tbc_pkg::IN_W-1:0] v_in [6];
    logic signed [tbc_pkg::IN_W-1:0] w_in [6];
    logic [tbc_pkg::IN_W-1:0]        v_mag [6];
    logic [tbc_pkg::IN_W-1:0]        w_mag [6];
    logic [tbc_pkg::DIV_NW-1:0]      cn [6];
    logic [tbc_pkg::DIV_DW-1:0]      cd [6];
    logic [tbc_pkg::DIV_QBITS-1:0]   cq [6];
    logic                            covf [6];
    side1_t                          side1_next;
    side1_t                          side1_reg [tbc_pkg::DIV_LAT];
    logic                            vld1_reg  [tbc_pkg::DIV_LAT];

    always_comb begin
        v_in[0] = in_word.item.ax;
        v_in[1] = in_word.item.bx;
        v_in[2] = in_word.item.cx;
        v_in[3] = in_word.item.ay;
        v_in[4] = in_word.item.by;
        v_in[5] = in_word.item.cy;
        w_in[0] = in_word.item.aw;
        w_in[1] = in_word.item.bw;
        w_in[2] = in_word.item.cw;
        w_in[3] = in_word.item.aw;
        w_in[4] = in_word.item.bw;
        w_in[5] = in_word.item.cw;
        side1_next.px     = in_word.item.px;
        side1_next.py     = in_word.item.py;
        side1_next.zero_w = in_word.zero_w;
        for (int k = 0; k < 6; k++) begin
            v_mag[k] = v_in[k][tbc_pkg::IN_W-1] ? tbc_pkg::IN_W'(-v_in[k]) : v_in[k];
            w_mag[k] = w_in[k][tbc_pkg::IN_W-1] ? tbc_pkg::IN_W'(-w_in[k]) : w_in[k];
            cn[k] = tbc_pkg::DIV_NW'({v_mag[k], {tbc_pkg::COORD_FRAC_BITS{1'b0}}});
            cd[k] = (w_in[k] == '0) ? tbc_pkg::DIV_DW'(1) : tbc_pkg::DIV_DW'(w_mag[k]);
            side1_next.neg[k] = v_in[k][tbc_pkg::IN_W-1] ^ w_in[k][tbc_pkg::IN_W-1];
        end
    end

    for (genvar k = 0; k < 6; k++) begin : g_cdiv
        tbc_div u_div (
            .aclk    (aclk),
            .en      (adv),
            .n_in    (cn[k]),
            .d_in    (cd[k]),
            .q_out   (cq[k]),
            .ovf_out (covf[k])
        );
    end

    // edge functions
    logic signed [tbc_pkg::IN_W-1:0]   c1_v_reg [6];
    logic signed [tbc_pkg::IN_W-1:0]   c1_px_reg, c1_py_reg;
    logic                              c1_zero_w_reg;
    logic signed [tbc_pkg::DIFF_W-1:0] c2_dx01_reg, c2_dy21_reg, c2_dy01_reg, c2_dx21_reg;
    logic signed [tbc_pkg::DIFF_W-1:0] c2_dpx1_reg, c2_dpy1_reg, c2_dpx2_reg, c2_dpy2_reg;
    logic signed [tbc_pkg::DIFF_W-1:0] c2_dy02_reg, c2_dx02_reg;
    logic                              c2_zero_w_reg;
    logic signed [tbc_pkg::PROD_W-1:0] c3_pa1_reg, c3_pa2_reg, c3_pe1_reg, c3_pe2_reg;
    logic signed [tbc_pkg::PROD_W-1:0] c3_pf1_reg, c3_pf2_reg;
    logic                              c3_zero_w_reg;
    logic signed [tbc_pkg::EDGE_W-1:0] c4_area_reg, c4_ea_reg, c4_eb_reg;
    logic                              c4_zero_w_reg;
    logic [tbc_pkg::EDGE_W-1:0]        area_abs, ea_abs, eb_abs;
    logic [tbc_pkg::DIV_DW-1:0]        c5_area_reg, c5_ea_reg, c5_eb_reg;
    side2_t                            c5_side_reg;
    logic                              c1_vld_reg, c2_vld_reg, c3_vld_reg, c4_vld_reg;
    logic                              c5_vld_reg;

    assign area_abs = c4_area_reg[tbc_pkg::EDGE_W-1] ? -c4_area_reg : c4_area_reg;
    assign ea_abs   = c4_ea_reg[tbc_pkg::EDGE_W-1]   ? -c4_ea_reg   : c4_ea_reg;
    assign eb_abs   = c4_eb_reg[tbc_pkg::EDGE_W-1]   ? -c4_eb_reg   : c4_eb_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            side1_reg[0] <= side1_next;
            for (int i = 1; i < tbc_pkg::DIV_LAT; i++) side1_reg[i] <= side1_reg[i-1];

            for (int k = 0; k < 6; k++) begin
                c1_v_reg[k] <= tbc_pkg::sat_coord(cq[k], covf[k],
                                                  side1_reg[tbc_pkg::DIV_LAT-1].neg[k]);
            end
            c1_px_reg     <= side1_reg[tbc_pkg::DIV_LAT-1].px;
            c1_py_reg     <= side1_reg[tbc_pkg::DIV_LAT-1].py;
            c1_zero_w_reg <= side1_reg[tbc_pkg::DIV_LAT-1].zero_w;

            c2_dx01_reg   <= tbc_pkg::DIFF_W'(c1_v_reg[0]) - tbc_pkg::DIFF_W'(c1_v_reg[1]);
            c2_dy21_reg   <= tbc_pkg::DIFF_W'(c1_v_reg[5]) - tbc_pkg::DIFF_W'(c1_v_reg[4]);
            c2_dy01_reg   <= tbc_pkg::DIFF_W'(c1_v_reg[3]) - tbc_pkg::DIFF_W'(c1_v_reg[4]);
            c2_dx21_reg   <= tbc_pkg::DIFF_W'(c1_v_reg[2]) - tbc_pkg::DIFF_W'(c1_v_reg[1]);
            c2_dpx1_reg   <= tbc_pkg::DIFF_W'(c1_px_reg) - tbc_pkg::DIFF_W'(c1_v_reg[1]);
            c2_dpy1_reg   <= tbc_pkg::DIFF_W'(c1_py_reg) - tbc_pkg::DIFF_W'(c1_v_reg[4]);
            c2_dpx2_reg   <= tbc_pkg::DIFF_W'(c1_px_reg) - tbc_pkg::DIFF_W'(c1_v_reg[2]);
            c2_dpy2_reg   <= tbc_pkg::DIFF_W'(c1_py_reg) - tbc_pkg::DIFF_W'(c1_v_reg[5]);
            c2_dy02_reg   <= tbc_pkg::DIFF_W'(c1_v_reg[3]) - tbc_pkg::DIFF_W'(c1_v_reg[5]);
            c2_dx02_reg   <= tbc_pkg::DIFF_W'(c1_v_reg[0]) - tbc_pkg::DIFF_W'(c1_v_reg[2]);
            c2_zero_w_reg <= c1_zero_w_reg;

            c3_pa1_reg    <= c2_dx01_reg * c2_dy21_reg;
            c3_pa2_reg    <= c2_dy01_reg * c2_dx21_reg;
            c3_pe1_reg    <= c2_dpx1_reg * c2_dy21_reg;
            c3_pe2_reg    <= c2_dpy1_reg * c2_dx21_reg;
            c3_pf1_reg    <= c2_dpx2_reg * c2_dy02_reg;
            c3_pf2_reg    <= c2_dpy2_reg * c2_dx02_reg;
            c3_zero_w_reg <= c2_zero_w_reg;

            c4_area_reg   <= tbc_pkg::EDGE_W'(c3_pa2_reg) - tbc_pkg::EDGE_W'(c3_pa1_reg);
            c4_ea_reg     <= tbc_pkg::EDGE_W'(c3_pe2_reg) - tbc_pkg::EDGE_W'(c3_pe1_reg);
            c4_eb_reg     <= tbc_pkg::EDGE_W'(c3_pf2_reg) - tbc_pkg::EDGE_W'(c3_pf1_reg);
            c4_zero_w_reg <= c3_zero_w_reg;

            c5_area_reg       <= area_abs[tbc_pkg::DIV_DW-1:0];
            c5_ea_reg         <= ea_abs[tbc_pkg::DIV_DW-1:0];
            c5_eb_reg         <= eb_abs[tbc_pkg::DIV_DW-1:0];
            c5_side_reg.degen <= c4_zero_w_reg || (c4_area_reg == '0);
            c5_side_reg.neg_a <= c4_ea_reg[tbc_pkg::EDGE_W-1] ^ c4_area_reg[tbc_pkg::EDGE_W-1];
            c5_side_reg.neg_b <= c4_eb_reg[tbc_pkg::EDGE_W-1] ^ c4_area_reg[tbc_pkg::EDGE_W-1];
        end
    end

    // weight divide
    logic [tbc_pkg::DIV_NW-1:0]    wn_a, wn_b;
    logic [tbc_pkg::DIV_DW-1:0]    wd;
    logic [tbc_pkg::DIV_QBITS-1:0] qa, qb;
    logic                          ovf_a, ovf_b;
    side2_t                        side2_reg [tbc_pkg::DIV_LAT];
    logic                          vld2_reg  [tbc_pkg::DIV_LAT];

    assign wn_a = tbc_pkg::DIV_NW'({c5_ea_reg, {tbc_pkg::WEIGHT_FRAC_BITS{1'b0}}});
    assign wn_b = tbc_pkg::DIV_NW'({c5_eb_reg, {tbc_pkg::WEIGHT_FRAC_BITS{1'b0}}});
    assign wd   = (c5_area_reg == '0) ? tbc_pkg::DIV_DW'(1) : c5_area_reg;

    tbc_div u_div_alpha (
        .aclk    (aclk),
        .en      (adv),
        .n_in    (wn_a),
        .d_in    (wd),
        .q_out   (qa),
        .ovf_out (ovf_a)
    );

    tbc_div u_div_beta (
        .aclk    (aclk),
        .en      (adv),
        .n_in    (wn_b),
        .d_in    (wd),
        .q_out   (qb),
        .ovf_out (ovf_b)
    );

    side2_t                           s2_last;
    logic signed [tbc_pkg::OUT_W-1:0] c6_alpha_reg, c6_beta_reg;
    logic                             c6_degen_reg;
    logic                             c6_vld_reg;
    logic signed [tbc_pkg::OUT_W+1:0] g_sum;
    logic signed [tbc_pkg::OUT_W-1:0] g_sat;

    assign s2_last = side2_reg[tbc_pkg::DIV_LAT-1];

    always_comb begin
        g_sum = tbc_pkg::W_ONE - (tbc_pkg::OUT_W+2)'(c6_alpha_reg)
                               - (tbc_pkg::OUT_W+2)'(c6_beta_reg);
        if (g_sum < (tbc_pkg::OUT_W+2)'(tbc_pkg::W_MIN)) g_sat = tbc_pkg::W_MIN;
        else if (g_sum > (tbc_pkg::OUT_W+2)'(tbc_pkg::W_MAX)) g_sat = tbc_pkg::W_MAX;
        else g_sat = g_sum[tbc_pkg::OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side2_reg[0] <= c5_side_reg;
            for (int i = 1; i < tbc_pkg::DIV_LAT; i++) side2_reg[i] <= side2_reg[i-1];

            c6_alpha_reg <= s2_last.degen ? '0 : tbc_pkg::sat_weight(qa, ovf_a, s2_last.neg_a);
            c6_beta_reg  <= s2_last.degen ? '0 : tbc_pkg::sat_weight(qb, ovf_b, s2_last.neg_b);
            c6_degen_reg <= s2_last.degen;

            m_weight_alpha <= c6_alpha_reg;
            m_weight_beta  <= c6_beta_reg;
            m_weight_gamma <= c6_degen_reg ? '0 : g_sat;
            m_degenerate   <= c6_degen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tbc_pkg::DIV_LAT; i++) begin
                vld1_reg[i] <= 1'b0;
                vld2_reg[i] <= 1'b0;
            end
            c1_vld_reg  <= 1'b0;
            c2_vld_reg  <= 1'b0;
            c3_vld_reg  <= 1'b0;
            c4_vld_reg  <= 1'b0;
            c5_vld_reg  <= 1'b0;
            c6_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg[0] <= in_valid;
            for (int i = 1; i < tbc_pkg::DIV_LAT; i++) vld1_reg[i] <= vld1_reg[i-1];
            c1_vld_reg  <= vld1_reg[tbc_pkg::DIV_LAT-1];
            c2_vld_reg  <= c1_vld_reg;
            c3_vld_reg  <= c2_vld_reg;
            c4_vld_reg  <= c3_vld_reg;
            c5_vld_reg  <= c4_vld_reg;
            vld2_reg[0] <= c5_vld_reg;
            for (int i = 1; i < tbc_pkg::DIV_LAT; i++) vld2_reg[i] <= vld2_reg[i-1];
            c6_vld_reg  <= vld2_reg[tbc_pkg::DIV_LAT-1];
            m_valid_reg <= c6_vld_reg;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/triangle_barycentric_unit.sv */
// Barycentric weight unit, top level: front end, word queue, back end.
// An accepted word passes through the front register, the queue and the back-end pipeline.
// Throughput: one word per cycle while the output is not held; set by the fully pipelined bit-per-stage dividers.
// Back end stalls as a whole when the output register is held.
// Reset (aresetn, synchronous) empties front, queue and pipeline; payload not cleared.
// Depends on tbc_pkg, tbc_front, tbc_queue, tbc_div, tbc_back.
`default_nettype none
module triangle_barycentric_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_a_x,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_a_y,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_a_w,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_b_x,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_b_y,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_b_w,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_c_x,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_c_y,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_vertex_c_w,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_point_x,
    input  wire logic signed [tbc_pkg::IN_W-1:0] s_point_y,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [tbc_pkg::OUT_W-1:0]     m_weight_alpha,
    output logic signed [tbc_pkg::OUT_W-1:0]     m_weight_beta,
    output logic signed [tbc_pkg::OUT_W-1:0]     m_weight_gamma,
    output logic                                 m_degenerate
);

    logic               fq_valid, fq_ready;
    tbc_pkg::tbc_word_t fq_word;
    logic               qb_valid, qb_ready;
    tbc_pkg::tbc_word_t qb_word;

    tbc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_vertex_a_x (s_vertex_a_x),
        .s_vertex_a_y (s_vertex_a_y),
        .s_vertex_a_w (s_vertex_a_w),
        .s_vertex_b_x (s_vertex_b_x),
        .s_vertex_b_y (s_vertex_b_y),
        .s_vertex_b_w (s_vertex_b_w),
        .s_vertex_c_x (s_vertex_c_x),
        .s_vertex_c_y (s_vertex_c_y),
        .s_vertex_c_w (s_vertex_c_w),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .out_valid    (fq_valid),
        .out_ready    (fq_ready),
        .out_word     (fq_word)
    );

    tbc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_word   (fq_word),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_word  (qb_word)
    );

    tbc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (qb_valid),
        .in_ready       (qb_ready),
        .in_word        (qb_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_weight_alpha (m_weight_alpha),
        .m_weight_beta  (m_weight_beta),
        .m_weight_gamma (m_weight_gamma),
        .m_degenerate   (m_degenerate)
    );

endmodule
`default_nettype wire

/* hw/rtl/tbc_checker.sv */
// Port-level checks for the barycentric weight unit, bound to the top level.
// Depends on tbc_pkg and triangle_barycentric_unit.
`default_nettype none
module tbc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic signed [tbc_pkg::OUT_W-1:0] m_weight_alpha,
    input wire logic signed [tbc_pkg::OUT_W-1:0] m_weight_beta,
    input wire logic signed [tbc_pkg::OUT_W-1:0] m_weight_gamma,
    input wire logic                            m_degenerate
);

    logic signed [tbc_pkg::OUT_W+1:0] w_sum;

    assign w_sum = (tbc_pkg::OUT_W+2)'(m_weight_alpha) + (tbc_pkg::OUT_W+2)'(m_weight_beta)
                 + (tbc_pkg::OUT_W+2)'(m_weight_gamma);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid straight after reset");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |->
            m_weight_alpha == '0 && m_weight_beta == '0 && m_weight_gamma == '0)
        else $error("degenerate word carries non-zero weights");

    a_weights_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate && m_weight_gamma != tbc_pkg::W_MAX &&
        m_weight_gamma != tbc_pkg::W_MIN |-> w_sum == tbc_pkg::W_ONE)
        else $error("unsaturated weights do not sum to one");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_weight_alpha) &&
            $stable(m_weight_beta) && $stable(m_weight_gamma) && $stable(m_degenerate))
        else $error("stalled result word changed");

endmodule

bind triangle_barycentric_unit tbc_checker u_tbc_checker (.*);
`default_nettype wire
